### rtl/positional_insert_delete_list_unit_defines.svh
// assertion macros shared by the list unit rtl
// expects clk and rst_n in the scope of each use
`ifndef POSITIONAL_INSERT_DELETE_LIST_UNIT_DEFINES_SVH
`define POSITIONAL_INSERT_DELETE_LIST_UNIT_DEFINES_SVH

// same-cycle implication, muted during reset
`define PIDL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, muted during reset
`define PIDL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pidl_pkg.sv
// shared codes and field widths for the positional list unit
// no dependencies
package pidl_pkg;

  localparam int POS_BITS       = 7;
  localparam int VALUE_BITS     = 32;
  localparam int LEN_BITS       = 7;
  localparam int CMD_BITS       = 3;
  localparam int STATUS_BITS    = 2;
  localparam int IN_TDATA_BITS  = 40;
  localparam int OUT_TDATA_BITS = 48;

  // command codes
  localparam logic [CMD_BITS-1:0] CMD_INSERT  = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_APPEND  = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_DELETE  = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_REPLACE = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_READ    = 3'd4;

  // result status codes
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

endpackage

### rtl/positional_insert_delete_list_unit.sv
// positional insert/delete list: sequencer, count and result register
// depends on pidl_pkg, pidl_ram and positional_insert_delete_list_unit_defines.svh
//
//  channel | dir | tdata (low bit up)                        | tuser
//  --------+-----+-------------------------------------------+-----------
//  in_     | in  | position[6:0], value[38:7], zero pad      | cmd[2:0]
//  out_    | out | read_data[31:0], length[38:32],            | none
//          |     | status[40:39], zero pad                   |
//
//  a command passes CHECK, then SHIFT and FINAL for an insert or delete that
//  succeeds, or RDWAIT for a read, then DONE; insert or delete moves m entries
//  (count - position, one less for delete)
//  the shift moves one entry per cycle through the single memory port pair
//  reset clears state, count and the result valid; the store is not cleared
//  in_tready is high only while idle; a result may wait in the output register
`include "positional_insert_delete_list_unit_defines.svh"

module positional_insert_delete_list_unit #(
  parameter int CAPACITY     = 64,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // slave side
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [pidl_pkg::IN_TDATA_BITS-1:0]   in_tdata,   // position, value
  input  logic [pidl_pkg::CMD_BITS-1:0]        in_tuser,   // cmd
  // master side
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [pidl_pkg::OUT_TDATA_BITS-1:0]  out_tdata   // read_data, length, status
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CMPW  = (CW > pidl_pkg::POS_BITS) ? CW : pidl_pkg::POS_BITS;
  localparam int WIDEW = (ELEMENT_BITS > pidl_pkg::VALUE_BITS) ?
                         ELEMENT_BITS : pidl_pkg::VALUE_BITS;
  localparam int OUT_USED = pidl_pkg::VALUE_BITS + pidl_pkg::LEN_BITS +
                            pidl_pkg::STATUS_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT,
    S_FINAL,
    S_RDWAIT,
    S_DONE
  } state_t;

  // registers
  state_t                               state_r, state_nxt;
  logic [pidl_pkg::CMD_BITS-1:0]        cmd_r, cmd_nxt;
  logic [pidl_pkg::POS_BITS-1:0]        pos_r, pos_nxt;
  logic [ELEMENT_BITS-1:0]              val_r, val_nxt;
  logic [CW-1:0]                        count_r, count_nxt;
  logic [AW-1:0]                        cursor_r, cursor_nxt;
  logic [AW-1:0]                        dst_r, dst_nxt;
  logic [AW-1:0]                        tgt_r, tgt_nxt;
  logic [CW-1:0]                        moves_r, moves_nxt;
  logic                                 pend_r, pend_nxt;
  logic [pidl_pkg::STATUS_BITS-1:0]     status_r, status_nxt;
  logic [pidl_pkg::VALUE_BITS-1:0]      rdres_r, rdres_nxt;
  logic                                 out_tvalid_r, out_tvalid_nxt;
  logic [pidl_pkg::OUT_TDATA_BITS-1:0]  out_tdata_r, out_tdata_nxt;

  // memory port
  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [ELEMENT_BITS-1:0] ram_wdata, ram_rdata;

  // decode helpers
  logic                            is_ins, is_del;
  logic [CMPW-1:0]                 cnt_x, pos_x, cap_x, ins_pos;
  logic [AW-1:0]                   step_val;
  logic [WIDEW-1:0]                val_wide, rd_wide;
  logic [CMPW-1:0]                 len_x;
  logic [pidl_pkg::VALUE_BITS-1:0] in_value;
  logic [pidl_pkg::POS_BITS-1:0]   in_position;

  // check helpers
  logic                            chk_full_done, chk_quiet;

  assign in_position = in_tdata[pidl_pkg::POS_BITS-1:0];
  assign in_value    = in_tdata[pidl_pkg::POS_BITS +: pidl_pkg::VALUE_BITS];
  assign val_wide    = WIDEW'(in_value);
  assign rd_wide     = WIDEW'(ram_rdata);

  assign is_ins  = (cmd_r == pidl_pkg::CMD_INSERT) || (cmd_r == pidl_pkg::CMD_APPEND);
  assign is_del  = (cmd_r == pidl_pkg::CMD_DELETE);
  assign cnt_x   = CMPW'(count_r);
  assign pos_x   = CMPW'(pos_r);
  assign cap_x   = CMPW'(CAPACITY);
  // append goes at the current end regardless of position
  assign ins_pos = (cmd_r == pidl_pkg::CMD_APPEND) ? cnt_x : pos_x;

  // cursor stepper: down for insert, up for delete
  assign step_val = cursor_r + (is_del ? AW'(1) : {AW{1'b1}});

  assign len_x = CMPW'(count_r);

  pidl_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ELEMENT_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    count_nxt      = count_r;
    cursor_nxt     = cursor_r;
    dst_nxt        = dst_r;
    tgt_nxt        = tgt_r;
    moves_nxt      = moves_r;
    pend_nxt       = 1'b0;
    status_nxt     = status_r;
    rdres_nxt      = rdres_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    ram_we         = 1'b0;
    ram_waddr      = tgt_r;
    ram_wdata      = val_r;
    ram_re         = 1'b0;
    ram_raddr      = step_val;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tuser;
          pos_nxt   = in_position;
          val_nxt   = val_wide[ELEMENT_BITS-1:0];
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        rdres_nxt  = '0;
        status_nxt = pidl_pkg::ST_OK;
        state_nxt  = S_DONE;
        if (is_ins) begin
          tgt_nxt = ins_pos[AW-1:0];
          if (ins_pos > cnt_x) begin
            status_nxt = pidl_pkg::ST_RANGE;
          end else if (cnt_x == cap_x) begin
            status_nxt = pidl_pkg::ST_FULL;
          end else begin
            // entries from count-1 down to the target move up one place
            cursor_nxt = cnt_x[AW-1:0];
            moves_nxt  = CW'(cnt_x - ins_pos);
            state_nxt  = S_SHIFT;
          end
        end else if (pos_x >= cnt_x) begin
          // delete, replace, read out of range and unknown commands
          status_nxt = pidl_pkg::ST_RANGE;
        end else begin
          tgt_nxt = pos_x[AW-1:0];
          case (cmd_r)
            pidl_pkg::CMD_DELETE: begin
              // entries above the target move down one place
              cursor_nxt = pos_x[AW-1:0];
              moves_nxt  = CW'(cnt_x - pos_x - CMPW'(1));
              state_nxt  = S_SHIFT;
            end
            pidl_pkg::CMD_REPLACE: begin
              ram_we    = 1'b1;
              ram_waddr = pos_x[AW-1:0];
            end
            pidl_pkg::CMD_READ: begin
              ram_re    = 1'b1;
              ram_raddr = pos_x[AW-1:0];
              state_nxt = S_RDWAIT;
            end
            default: begin
              status_nxt = pidl_pkg::ST_RANGE;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // read the next source while the previous one is written back
        ram_we    = pend_r;
        ram_waddr = dst_r;
        ram_wdata = ram_rdata;
        if (moves_r != '0) begin
          ram_re     = 1'b1;
          ram_raddr  = step_val;
          pend_nxt   = 1'b1;
          dst_nxt    = cursor_r;
          cursor_nxt = step_val;
          moves_nxt  = moves_r - CW'(1);
        end else if (!pend_r) begin
          state_nxt = S_FINAL;
        end
      end

      S_FINAL: begin
        if (is_ins) begin
          ram_we    = 1'b1;
          ram_waddr = tgt_r;
          count_nxt = count_r + CW'(1);
        end else begin
          count_nxt = count_r - CW'(1);
        end
        state_nxt = S_DONE;
      end

      S_RDWAIT: begin
        rdres_nxt = rd_wide[pidl_pkg::VALUE_BITS-1:0];
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {(pidl_pkg::OUT_TDATA_BITS - OUT_USED)'(0), status_r,
                            len_x[pidl_pkg::LEN_BITS-1:0], rdres_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    // payload
    cmd_r       <= cmd_nxt;
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    cursor_r    <= cursor_nxt;
    dst_r       <= dst_nxt;
    tgt_r       <= tgt_nxt;
    status_r    <= status_nxt;
    rdres_r     <= rdres_nxt;
    out_tdata_r <= out_tdata_nxt;
    // control
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      moves_r      <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      moves_r      <= moves_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign chk_full_done = (state_r == S_DONE) && (status_r == pidl_pkg::ST_FULL);
  assign chk_quiet     = (state_r == S_IDLE) || (state_r == S_DONE);

  // checks
  `PIDL_ASSERT_IMP(a_count_cap, 1'b1, count_r <= CW'(CAPACITY), "list count above capacity")
  `PIDL_ASSERT_IMP(a_full_status, chk_full_done, count_r == CW'(CAPACITY), "full with room")
  `PIDL_ASSERT_IMP(a_no_idle_write, chk_quiet, !ram_we, "store written outside a command")
  `PIDL_ASSERT_NEXT(a_count_hold, state_r != S_FINAL, $stable(count_r), "count moved early")

endmodule

### rtl/pidl_ram.sv
// element store: one write port, one read port, registered read data
// no dependencies
module pidl_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
